[rtl/window_statistics_engine_unit_macros.svh]
// Assertion macros used by the window statistics engine back end.
`ifndef WINDOW_STATISTICS_ENGINE_UNIT_MACROS_SVH
`define WINDOW_STATISTICS_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window statistics assertion failed");

// Next-cycle implication, disabled during reset.
`define WSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window statistics assertion failed");

`endif

[rtl/wse_pkg.sv]
// Shared types and codes of the window statistics engine.
package wse_pkg;

    localparam int IN_SAMPLE_W = 16;
    localparam int OUT_W       = 48;
    localparam int FRAC_W      = 16;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MEASURE_SELECT = 2'd0;
    localparam logic [1:0] REG_ISO_THRESHOLD  = 2'd1;

    // Measure codes
    localparam logic [2:0] MEAS_MEAN   = 3'd0;
    localparam logic [2:0] MEAS_SECOND = 3'd1;
    localparam logic [2:0] MEAS_MAD    = 3'd2;
    localparam logic [2:0] MEAS_MIN    = 3'd3;
    localparam logic [2:0] MEAS_MAX    = 3'd4;
    localparam logic [2:0] MEAS_ISO    = 3'd5;

    // One classified pixel transaction
    typedef struct packed {
        logic [IN_SAMPLE_W-1:0] sample;
        logic                   last;
    } t_item;

    // Queue flags seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [4:0] {
        S_ACCUM = 5'b00001,
        S_PREP  = 5'b00010,
        S_PASS  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

endpackage

[rtl/wse_front.sv]
// Front end: accepts pixel transactions, masks the sample and feeds the queue.
module wse_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [wse_pkg::IN_SAMPLE_W-1:0]     i_sample,
    input  logic                                i_last_of_window,
    input  wse_pkg::t_q_status                  i_q,
    output logic                                o_push,
    output wse_pkg::t_item                      o_item
);

    localparam logic [wse_pkg::IN_SAMPLE_W-1:0] MASK = (SAMPLE_BITS >= wse_pkg::IN_SAMPLE_W) ?
        {wse_pkg::IN_SAMPLE_W{1'b1}} :
        wse_pkg::IN_SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic           r_valid, n_valid;
    wse_pkg::t_item r_item;
    logic           accept;

    assign o_push = r_valid && !i_q.full;
    assign busy   = r_valid && i_q.full;
    assign accept = start && !busy;
    assign o_item = r_item;

    // Holding stage in front of the queue
    always_comb begin
        n_valid = accept || (r_valid && !o_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.sample <= i_sample & MASK;
            r_item.last   <= i_last_of_window;
        end
    end

endmodule

[rtl/wse_fifo.sv]
// Short queue between the front end and the back end.
module wse_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wse_pkg::t_item     i_item,
    input  logic               i_pop,
    output wse_pkg::t_item     o_item,
    output wse_pkg::t_q_status o_q
);

    localparam int CNT_W = wse_pkg::Q_PTR_W + 1;

    wse_pkg::t_item                 r_mem [wse_pkg::Q_DEPTH];
    logic [wse_pkg::Q_PTR_W-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0]               r_cnt;
    logic                           do_push, do_pop;

    assign o_q.full  = (r_cnt == CNT_W'(wse_pkg::Q_DEPTH));
    assign o_q.empty = (r_cnt == '0);
    assign do_push   = i_push && !o_q.full;
    assign do_pop    = i_pop && !o_q.empty;
    assign o_item    = r_mem[r_rd];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_item;
    end

endmodule

[rtl/wse_div.sv]
// Bit-serial restoring divider giving floor(num * 2^16 / den), saturated to 48 bits.
module wse_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [DEN_W-1:0]              i_den,
    output logic                          o_done,
    output logic [wse_pkg::OUT_W-1:0]     o_quot
);

    localparam int DVD_W = NUM_W + wse_pkg::FRAC_W;
    localparam int QX_W  = (DVD_W > wse_pkg::OUT_W) ? DVD_W : wse_pkg::OUT_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   sh;
    logic             qb;
    logic [QX_W-1:0]  qx;

    // One quotient bit per cycle
    always_comb begin
        sh = {r_rem, r_dvd[DVD_W-1]};
        qb = (sh >= {1'b0, r_den});
        qx = QX_W'(r_dvd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, {wse_pkg::FRAC_W{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= qb ? DEN_W'(sh - {1'b0, r_den}) : sh[DEN_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], qb};
        end
    end

    assign o_done = r_done;
    assign o_quot = ((qx >> wse_pkg::OUT_W) != '0) ? {wse_pkg::OUT_W{1'b1}} :
                    qx[wse_pkg::OUT_W-1:0];

endmodule

[rtl/wse_back.sv]
// Back end: window store, running statistics, deviation pass and result selection.
`include "window_statistics_engine_unit_macros.svh"
module wse_back #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wse_pkg::t_item                i_item,
    input  wse_pkg::t_q_status            i_q,
    output logic                          o_pop,
    input  logic [2:0]                    i_measure_select,
    input  logic [31:0]                   i_iso_threshold,
    output logic                          o_strobe,
    output logic [wse_pkg::OUT_W-1:0]     o_measure_value,
    output logic                          o_status
);

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int XW     = SAMPLE_BITS;
    localparam int PROD_W = XW + CNT_W;
    localparam int SQ_W   = 2 * XW + CNT_W;
    localparam int DEV_W  = PROD_W + CNT_W;
    localparam int TN_W   = 32 + CNT_W;
    localparam int CMP_W  = ((PROD_W + wse_pkg::FRAC_W) > TN_W) ?
                            (PROD_W + wse_pkg::FRAC_W) : TN_W;
    localparam int NUM_W  = (DEV_W > SQ_W) ? DEV_W : SQ_W;
    localparam int DEN_W  = 2 * CNT_W;

    wse_pkg::t_state r_state;
    logic [XW-1:0]     r_store [WINDOW_MAX];
    logic [CNT_W-1:0]  r_count, r_k, r_iso;
    logic [PROD_W-1:0] r_sum, r_prod;
    logic [SQ_W-1:0]   r_sq;
    logic [XW-1:0]     r_min, r_max, r_rd;
    logic              r_ovf, r_v1, r_v2;
    logic [DEV_W-1:0]  r_dev;
    logic [DEN_W-1:0]  r_nsq;
    logic [TN_W-1:0]   r_tn;
    logic              r_strobe, r_status;
    logic [wse_pkg::OUT_W-1:0] r_value;

    logic [XW-1:0]     x;
    logic [2*XW-1:0]   xsq;
    logic              store_ok, we, rd_en, pass_done;
    logic [PROD_W-1:0] gap;
    logic              in_iso;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [wse_pkg::OUT_W-1:0] div_quot;

    // Load side decode
    always_comb begin
        o_pop     = (r_state == wse_pkg::S_ACCUM) && !i_q.empty;
        x         = XW'(i_item.sample);
        xsq       = x * x;
        store_ok  = (r_count < CNT_W'(WINDOW_MAX));
        we        = o_pop && store_ok;
        rd_en     = (r_state == wse_pkg::S_PASS) && (r_k < r_count);
        pass_done = (r_state == wse_pkg::S_PASS) && !rd_en && !r_v1 && !r_v2;
        gap       = (r_prod >= r_sum) ? (r_prod - r_sum) : (r_sum - r_prod);
        in_iso    = (CMP_W'({gap, {wse_pkg::FRAC_W{1'b0}}}) < CMP_W'(r_tn));
    end

    // Divider operand selection
    always_comb begin
        div_num = NUM_W'(r_sum);
        div_den = DEN_W'(r_count);
        case (i_measure_select)
            wse_pkg::MEAS_SECOND: div_num = NUM_W'(r_sq);
            wse_pkg::MEAS_MAD: begin
                div_num = NUM_W'(r_dev);
                div_den = r_nsq;
            end
            wse_pkg::MEAS_ISO: div_num = NUM_W'(r_iso);
            default: div_num = NUM_W'(r_sum);
        endcase
        div_start = pass_done && (i_measure_select == wse_pkg::MEAS_MEAN ||
                    i_measure_select == wse_pkg::MEAS_SECOND ||
                    i_measure_select == wse_pkg::MEAS_MAD ||
                    i_measure_select == wse_pkg::MEAS_ISO);
    end

    // Window store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (we) r_store[r_count[ADDR_W-1:0]] <= x;
        if (rd_en) r_rd <= r_store[r_k[ADDR_W-1:0]];
    end

    // Sequencer and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wse_pkg::S_ACCUM;
            r_count  <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_ovf    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_v1     <= rd_en;
            r_v2     <= r_v1;
            unique case (r_state)
                wse_pkg::S_ACCUM: begin
                    if (o_pop) begin
                        if (store_ok) begin
                            if (r_count == '0) begin
                                r_min <= x;
                                r_max <= x;
                            end else begin
                                if (x != '0 && x < r_min) r_min <= x;
                                if (x > r_max) r_max <= x;
                            end
                            r_sum   <= r_sum + PROD_W'(x);
                            r_sq    <= r_sq + SQ_W'(xsq);
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.last) r_state <= wse_pkg::S_PREP;
                    end
                end
                wse_pkg::S_PREP: r_state <= wse_pkg::S_PASS;
                wse_pkg::S_PASS: begin
                    if (pass_done) begin
                        if (div_start) begin
                            r_state <= wse_pkg::S_DIV;
                        end else begin
                            r_state  <= wse_pkg::S_OUT;
                            r_strobe <= 1'b1;
                        end
                    end
                end
                wse_pkg::S_DIV: begin
                    if (div_done) begin
                        r_state  <= wse_pkg::S_OUT;
                        r_strobe <= 1'b1;
                    end
                end
                wse_pkg::S_OUT: begin
                    r_state <= wse_pkg::S_ACCUM;
                    r_count <= '0;
                    r_sum   <= '0;
                    r_sq    <= '0;
                    r_min   <= '0;
                    r_max   <= '0;
                    r_ovf   <= 1'b0;
                end
                default: r_state <= wse_pkg::S_ACCUM;
            endcase
        end
    end

    // Deviation pass datapath and result capture
    always_ff @(posedge i_clk) begin
        if (r_state == wse_pkg::S_PREP) begin
            r_nsq <= r_count * r_count;
            r_tn  <= i_iso_threshold * r_count;
            r_k   <= '0;
            r_dev <= '0;
            r_iso <= '0;
        end
        if (rd_en) r_k <= r_k + 1'b1;
        if (r_v1) r_prod <= r_count * r_rd;
        if (r_v2) begin
            r_dev <= r_dev + DEV_W'(gap);
            if (in_iso) r_iso <= r_iso + 1'b1;
        end
        if (pass_done) begin
            r_status <= r_ovf;
            case (i_measure_select)
                wse_pkg::MEAS_MIN: r_value <= wse_pkg::OUT_W'(r_min) << wse_pkg::FRAC_W;
                wse_pkg::MEAS_MAX: r_value <= wse_pkg::OUT_W'(r_max) << wse_pkg::FRAC_W;
                default:           r_value <= '0;
            endcase
        end
        if (div_done) r_value <= div_quot;
    end

    wse_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_strobe        = r_strobe;
    assign o_measure_value = r_value;
    assign o_status        = r_status;

    `WSE_ASSERT_NOW(a_strobe_in_out, i_clk, i_rst_n, r_strobe, r_state == wse_pkg::S_OUT)
    `WSE_ASSERT_NEXT(a_out_one_cycle, i_clk, i_rst_n, r_strobe, !r_strobe && r_count == '0)
    `WSE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(WINDOW_MAX))
    `WSE_ASSERT_NOW(a_div_done_state, i_clk, i_rst_n, div_done, r_state == wse_pkg::S_DIV)

endmodule

[rtl/window_statistics_engine_unit.sv]
// Flow: pixels enter at one per cycle unless busy; after the last one the result
//   strobes after the store pass (one read per pixel) and, for mean, moment,
//   deviation and iso, also after the bit-serial divider.
// Throughput: one pixel per cycle unless busy; one window at a time; no output stall.
// Reset: synchronous active low, clears control and statistics; the window
//   store is not cleared. Results strobe for one cycle; the value is held after it.
module window_statistics_engine_unit #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [wse_pkg::IN_SAMPLE_W-1:0]   i_sample,
    input  logic                              i_last_of_window,
    output logic                              o_strobe,
    output logic [wse_pkg::OUT_W-1:0]         o_measure_value,
    output logic                              o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic [2:0]  r_measure_select;
    logic [31:0] r_iso_threshold;
    logic        cfg_we;

    wse_pkg::t_q_status q_status;
    wse_pkg::t_item     front_item, back_item;
    logic               push, pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measure_select <= '0;
            r_iso_threshold  <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                wse_pkg::REG_MEASURE_SELECT: r_measure_select <= i_cfg_data[2:0];
                wse_pkg::REG_ISO_THRESHOLD:  r_iso_threshold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wse_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sample         (i_sample),
        .i_last_of_window (i_last_of_window),
        .i_q              (q_status),
        .o_push           (push),
        .o_item           (front_item)
    );

    wse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (back_item),
        .o_q     (q_status)
    );

    wse_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (back_item),
        .i_q              (q_status),
        .o_pop            (pop),
        .i_measure_select (r_measure_select),
        .i_iso_threshold  (r_iso_threshold),
        .o_strobe         (o_strobe),
        .o_measure_value  (o_measure_value),
        .o_status         (o_status)
    );

endmodule
